// ===== rtl/core/qtp_pkg.sv =====
`timescale 1ns / 1ps
// shared types, stage counts and the restoring divide step for the quintic trajectory point
// depends on nothing; every module of the block imports it
package qtp_pkg;

  localparam int SHAPE_BITS = 30;
  localparam int AXES       = 3;
  // phase divider: one quotient bit a stage, quotient reaches 2^30
  localparam int SD_N       = SHAPE_BITS + 1;
  // rate dividers for velocity and acceleration; the acceleration dividend needs 35 bits
  localparam int QD_N       = 35;
  localparam int SH_N       = 3;
  // axis: product stage, divide stages, output register
  localparam int AX_N       = QD_N + 2;
  localparam int ST_SD0     = 1;
  localparam int ST_SH0     = ST_SD0 + SD_N;
  localparam int ST_AX0     = ST_SH0 + SH_N;
  localparam int N_ST       = ST_AX0 + AX_N;

  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] pend;
    logic [32:0]        mag;
    logic               neg;
  } axis_in_t;

  typedef struct packed {
    axis_in_t [AXES-1:0] ax;
    logic [15:0]         dur;
    logic                past;
  } item_t;

  typedef struct packed {
    logic [31:0] h;
    logic [30:0] g;
    logic [31:0] a;
    logic        aneg;
  } shape_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] dvs);
    logic [32:0] sh;
    logic [32:0] df;
    sh = {rem, nb};
    df = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {1'b1, df[31:0]};
    end else begin
      return {1'b0, sh[31:0]};
    end
  endfunction

endpackage

// ===== rtl/core/quintic_trajectory_point.sv =====
`timescale 1ns / 1ps
// top level of the quintic minimum-jerk trajectory point: input stage, pipeline control
// depends on qtp_pkg, qtp_sdiv, qtp_shape and qtp_axis
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------------
//   in      | in_valid / in_stall   | start_x/y/z, end_x/y/z, duration, elapsed
//   out     | out_valid / out_stall | pos_x/y/z, vel_x/y/z, acc_x/y/z
//
// one transfer per cycle sustained while out_stall is low; the depth is set by the one-bit-a-stage
// phase divider (31 stages) and the velocity/acceleration dividers (35 stages)
// every stage has its own valid bit; a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up behind a stalled output and in_stall rises only
// when every stage holds an item
// synchronous reset clears the valid bits only; the data registers are not reset
module quintic_trajectory_point (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] start_z,
  input  logic [31:0] end_x,
  input  logic [31:0] end_y,
  input  logic [31:0] end_z,
  input  logic [15:0] duration,
  input  logic [15:0] elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [31:0] vel_x,
  output logic [31:0] vel_y,
  output logic [31:0] vel_z,
  output logic [31:0] acc_x,
  output logic [31:0] acc_y,
  output logic [31:0] acc_z
);
  import qtp_pkg::*;

  // valid bit and load enable of every stage, stage 0 is the input register
  logic [N_ST-1:0] v;
  logic [N_ST-1:0] en;

  item_t        item0, item0_next;
  logic [15:0]  t0;
  item_t        sd_item, sh_item;
  logic [SD_N-1:0] s;
  shape_t       sh;
  logic [31:0]  st_in  [AXES];
  logic [31:0]  end_in [AXES];
  logic [31:0]  pos_o  [AXES];
  logic [31:0]  vel_o  [AXES];
  logic [31:0]  acc_o  [AXES];

  // load enables: a stage moves if the output drains or some stage at or after it is empty
  always_comb begin
    logic all_full;
    all_full = 1'b1;
    for (int k = N_ST - 1; k >= 0; k--) begin
      all_full = all_full & v[k];
      en[k]    = !out_stall || !all_full;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[N_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < N_ST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // input stage: zero duration counts as one tick, per-axis move and its magnitude
  assign st_in[0]  = start_x;
  assign st_in[1]  = start_y;
  assign st_in[2]  = start_z;
  assign end_in[0] = end_x;
  assign end_in[1] = end_y;
  assign end_in[2] = end_z;

  always_comb begin
    logic signed [32:0] d;
    item0_next.dur  = (duration == 16'd0) ? 16'd1 : duration;
    item0_next.past = elapsed > item0_next.dur;
    for (int k = 0; k < AXES; k++) begin
      d = {end_in[k][31], end_in[k]} - {st_in[k][31], st_in[k]};
      item0_next.ax[k].p0   = st_in[k];
      item0_next.ax[k].pend = end_in[k];
      item0_next.ax[k].neg  = d[32];
      item0_next.ax[k].mag  = d[32] ? (33'd0 - d) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      item0 <= item0_next;
      t0    <= elapsed;
    end
  end

  // phase s = t/T in Q30
  qtp_sdiv u_sdiv (
    .clk      (clk),
    .en       (en[ST_SH0-1:ST_SD0]),
    .elapsed  (t0),
    .item_in  (item0),
    .s        (s),
    .item_out (sd_item)
  );

  // shape terms shared by all three axes
  qtp_shape u_shape (
    .clk      (clk),
    .en       (en[ST_AX0-1:ST_SH0]),
    .s        (s),
    .item_in  (sd_item),
    .sh       (sh),
    .item_out (sh_item)
  );

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    qtp_axis u_axis (
      .clk  (clk),
      .en   (en[N_ST-1:ST_AX0]),
      .ain  (sh_item.ax[k]),
      .dur  (sh_item.dur),
      .past (sh_item.past),
      .sh   (sh),
      .pos  (pos_o[k]),
      .vel  (vel_o[k]),
      .acc  (acc_o[k])
    );
  end

  assign pos_x = pos_o[0];
  assign pos_y = pos_o[1];
  assign pos_z = pos_o[2];
  assign vel_x = vel_o[0];
  assign vel_y = vel_o[1];
  assign vel_z = vel_o[2];
  assign acc_x = acc_o[0];
  assign acc_y = acc_o[1];
  assign acc_z = acc_o[2];

`ifndef SYNTHESIS
  // input held off only when the whole pipeline is occupied
  a_stall_full : assert property (@(posedge clk) disable iff (rst) in_stall |-> (&v))
    else $error("input stalled with a free stage");
  // an accepted transfer lands in the input stage
  a_accept : assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |=> v[0])
    else $error("accepted transfer lost at input stage");
  // reset empties the pipeline
  a_reset : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== rtl/core/qtp_sdiv.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider for the profile phase s = t * 2^30 / T, one bit a stage
// depends on qtp_pkg
module qtp_sdiv (
  input  logic                      clk,
  input  logic [qtp_pkg::SD_N-1:0]  en,
  input  logic [15:0]               elapsed,
  input  qtp_pkg::item_t            item_in,
  output logic [qtp_pkg::SD_N-1:0]  s,
  output qtp_pkg::item_t            item_out
);
  import qtp_pkg::*;

  logic [31:0]     rem       [SD_N];
  logic [SD_N-1:0] work      [SD_N];
  item_t           item      [SD_N];
  logic [31:0]     rem_next  [SD_N];
  logic [SD_N-1:0] work_next [SD_N];
  logic [31:0]     src_rem   [SD_N];
  logic [SD_N-1:0] src_work  [SD_N];
  item_t           src_item  [SD_N];

  always_comb begin
    logic [32:0] st;
    // dividend high part t>>1 seeds the remainder, t[0] is the first new bit
    src_rem[0]  = {17'd0, elapsed[15:1]};
    src_work[0] = {elapsed[0], (SD_N-1)'(0)};
    src_item[0] = item_in;
    for (int j = 1; j < SD_N; j++) begin
      src_rem[j]  = rem[j-1];
      src_work[j] = work[j-1];
      src_item[j] = item[j-1];
    end
    for (int j = 0; j < SD_N; j++) begin
      st = div_step(src_rem[j], src_work[j][SD_N-1], {16'd0, src_item[j].dur});
      rem_next[j]  = st[31:0];
      work_next[j] = {src_work[j][SD_N-2:0], st[32]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SD_N; j++) begin
      if (en[j]) begin
        rem[j]  <= rem_next[j];
        work[j] <= work_next[j];
        item[j] <= src_item[j];
      end
    end
  end

  assign s        = work[SD_N-1];
  assign item_out = item[SD_N-1];

endmodule

// ===== rtl/core/qtp_shape.sv =====
`timescale 1ns / 1ps
// three stage evaluation of the quintic shape terms h, g and a from the phase s
// depends on qtp_pkg
module qtp_shape (
  input  logic                     clk,
  input  logic [qtp_pkg::SH_N-1:0] en,
  input  logic [qtp_pkg::SD_N-1:0] s,
  input  qtp_pkg::item_t           item_in,
  output qtp_pkg::shape_t          sh,
  output qtp_pkg::item_t           item_out
);
  import qtp_pkg::*;

  localparam logic [SD_N-1:0] ONE    = SD_N'(1) << SHAPE_BITS;
  localparam logic [33:0]     POLY_C = 34'd10 << SHAPE_BITS;

  logic [30:0] a_s, a_s2, a_diff;
  logic [28:0] a_su;
  logic        a_aneg;
  item_t       a_item;
  logic [30:0] b_s3;
  logic [33:0] b_poly;
  logic [57:0] b_sq;
  logic [59:0] b_sd;
  logic        b_aneg;
  item_t       b_item;

  logic [30:0] u;
  logic [61:0] p_ss, p_su, p_s3;
  logic [64:0] p_h;
  logic [62:0] p_g;
  logic [65:0] p_a;
  logic [30:0] s2_next, s3_next, diff_next;
  logic [28:0] su_next;
  logic [33:0] poly_next;
  shape_t      sh_next;

  always_comb begin
    u         = ONE - s;
    p_ss      = s * s;
    p_su      = s * u;
    s2_next   = p_ss[60:30];
    su_next   = p_su[58:30];
    diff_next = (s > u) ? (s - u) : (u - s);
    // stage b
    p_s3      = a_s2 * a_s;
    s3_next   = p_s3[60:30];
    poly_next = POLY_C + 34'({a_s2, 2'b0}) + 34'({a_s2, 1'b0})
              - 34'({a_s, 4'b0}) + 34'(a_s);
    // stage c
    p_h       = b_s3 * b_poly;
    p_g       = 63'({b_sq, 5'b0}) - 63'({b_sq, 1'b0});
    p_a       = 66'({b_sd, 6'b0}) - 66'({b_sd, 2'b0});
    sh_next.h    = p_h[61:30];
    sh_next.g    = p_g[60:30];
    sh_next.a    = p_a[63:32];
    sh_next.aneg = b_aneg;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_s    <= s;
      a_s2   <= s2_next;
      a_su   <= su_next;
      a_diff <= diff_next;
      a_aneg <= s > u;
      a_item <= item_in;
    end
    if (en[1]) begin
      b_s3   <= s3_next;
      b_poly <= poly_next;
      b_sq   <= a_su * a_su;
      b_sd   <= a_su * a_diff;
      b_aneg <= a_aneg;
      b_item <= a_item;
    end
    if (en[2]) begin
      sh       <= sh_next;
      item_out <= b_item;
    end
  end

endmodule

// ===== rtl/core/qtp_axis.sv =====
`timescale 1ns / 1ps
// one axis: scale by the move, pipelined divides by T and T*T, saturation and output register
// depends on qtp_pkg
module qtp_axis (
  input  logic                     clk,
  input  logic [qtp_pkg::AX_N-1:0] en,
  input  qtp_pkg::axis_in_t        ain,
  input  logic [15:0]              dur,
  input  logic                     past,
  input  qtp_pkg::shape_t          sh,
  output logic [31:0]              pos,
  output logic [31:0]              vel,
  output logic [31:0]              acc
);
  import qtp_pkg::*;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] pend;
    logic        neg;
    logic        aneg;
    logic        past;
    logic [15:0] dur;
    logic [31:0] dd;
  } carry_t;

  function automatic logic [31:0] sat_mag(input logic [QD_N-1:0] q, input logic ng);
    if (ng) begin
      return (q >= QD_N'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      return (q >= QD_N'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[31:0];
    end
  endfunction

  // product stage
  logic signed [31:0] d_p0;
  logic [34:0]        d_pmag;
  logic [QD_N-1:0]    d_vx, d_ax;
  carry_t             d_c;

  logic [31:0]     vrem       [QD_N];
  logic [QD_N-1:0] vwork      [QD_N];
  logic [31:0]     arem       [QD_N];
  logic [QD_N-1:0] awork      [QD_N];
  carry_t          cy         [QD_N];
  logic [31:0]     vrem_next  [QD_N];
  logic [QD_N-1:0] vwork_next [QD_N];
  logic [31:0]     arem_next  [QD_N];
  logic [QD_N-1:0] awork_next [QD_N];
  logic [31:0]     src_vrem   [QD_N];
  logic [QD_N-1:0] src_vwork  [QD_N];
  logic [31:0]     src_arem   [QD_N];
  logic [QD_N-1:0] src_awork  [QD_N];
  carry_t          src_cy     [QD_N];

  logic [64:0] p_h, p_a;
  logic [63:0] p_g;
  carry_t      c_next;
  logic [32:0] mc;
  logic signed [34:0] psum;
  carry_t      last;

  always_comb begin
    p_h = ain.mag * sh.h;
    p_g = ain.mag * sh.g;
    p_a = ain.mag * sh.a;
    c_next.pos  = '0;
    c_next.pend = ain.pend;
    c_next.neg  = ain.neg;
    c_next.aneg = sh.aneg;
    c_next.past = past;
    c_next.dur  = dur;
    c_next.dd   = dur * dur;
  end

  always_comb begin
    logic [32:0] vs;
    logic [32:0] as;
    // position: clamp the offset to 2^32, add to the start, saturate
    mc   = (d_pmag > 35'h1_0000_0000) ? 33'h1_0000_0000 : d_pmag[32:0];
    psum = d_c.neg ? ({{3{d_p0[31]}}, d_p0} - {2'b0, mc})
                   : ({{3{d_p0[31]}}, d_p0} + {2'b0, mc});
    src_cy[0] = d_c;
    if (psum > 35'sd2147483647) begin
      src_cy[0].pos = 32'h7fff_ffff;
    end else if (psum < -35'sd2147483648) begin
      src_cy[0].pos = 32'h8000_0000;
    end else begin
      src_cy[0].pos = psum[31:0];
    end
    src_vrem[0]  = '0;
    src_vwork[0] = d_vx;
    src_arem[0]  = '0;
    src_awork[0] = d_ax;
    for (int j = 1; j < QD_N; j++) begin
      src_vrem[j]  = vrem[j-1];
      src_vwork[j] = vwork[j-1];
      src_arem[j]  = arem[j-1];
      src_awork[j] = awork[j-1];
      src_cy[j]    = cy[j-1];
    end
    for (int j = 0; j < QD_N; j++) begin
      vs = div_step(src_vrem[j], src_vwork[j][QD_N-1], {16'd0, src_cy[j].dur});
      as = div_step(src_arem[j], src_awork[j][QD_N-1], src_cy[j].dd);
      vrem_next[j]  = vs[31:0];
      vwork_next[j] = {src_vwork[j][QD_N-2:0], vs[32]};
      arem_next[j]  = as[31:0];
      awork_next[j] = {src_awork[j][QD_N-2:0], as[32]};
    end
    last = cy[QD_N-1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_p0   <= ain.p0;
      d_pmag <= p_h[64:30];
      d_vx   <= QD_N'(p_g[63:30]);
      d_ax   <= p_a[62:28];
      d_c    <= c_next;
    end
    for (int j = 0; j < QD_N; j++) begin
      if (en[j+1]) begin
        vrem[j]  <= vrem_next[j];
        vwork[j] <= vwork_next[j];
        arem[j]  <= arem_next[j];
        awork[j] <= awork_next[j];
        cy[j]    <= src_cy[j];
      end
    end
    if (en[AX_N-1]) begin
      pos <= last.past ? last.pend : last.pos;
      vel <= last.past ? 32'd0 : sat_mag(vwork[QD_N-1], last.neg);
      acc <= last.past ? 32'd0 : sat_mag(awork[QD_N-1], last.neg ^ last.aneg);
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for quintic_trajectory_point: queued driver, clocked monitor, fixed-point predictor
// depends on the block under test and nothing else
module tb;

  typedef struct packed {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [15:0] dur, elp;
  } setpoint_t;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz, ax, ay, az;
  } profile_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [31:0] start_x = 0, start_y = 0, start_z = 0, end_x = 0, end_y = 0, end_z = 0;
  logic [15:0] duration = 0, elapsed = 0;
  logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;

  setpoint_t pending_sp[$];
  profile_t  awaited_prof[$];
  int errors = 0, n_sent = 0, n_got = 0, hold_cnt = 0, phase = 0;
  bit hold_done = 0;

  quintic_trajectory_point dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // clamp the magnitude to 2^32, apply sign and base, then saturate to 32 bits
  function automatic logic [31:0] sat_word(longint base, longint unsigned mag, bit neg);
    longint v;
    if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
    v = neg ? base - longint'(mag) : base + longint'(mag);
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic profile_t min_jerk_point(setpoint_t sp);
    longint unsigned tt, t, s, u, s2, s3, poly, h, su, g, diff, a, m;
    logic [31:0] p0w[3], pew[3], pos[3], vel[3], acc[3];
    longint p0, d;
    bit aneg, neg;
    profile_t r;
    p0w = '{sp.sx, sp.sy, sp.sz};
    pew = '{sp.ex, sp.ey, sp.ez};
    tt = 64'(sp.dur);
    t = 64'(sp.elp);
    if (tt == 0) tt = 1;
    if (t > tt) begin
      // past the end: rest at the end position
      return '{sp.ex, sp.ey, sp.ez, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    end
    s = (t << 30) / tt;
    u = (64'd1 << 30) - s;
    s2 = (s * s) >> 30;
    s3 = (s2 * s) >> 30;
    poly = 10 * (64'd1 << 30) + 6 * s2 - 15 * s;
    h = (s3 * poly) >> 30;
    su = (s * u) >> 30;
    g = (30 * su * su) >> 30;
    aneg = s > u;
    diff = aneg ? s - u : u - s;
    a = (60 * su * diff) >> 32;
    for (int k = 0; k < 3; k++) begin
      p0 = longint'($signed(p0w[k]));
      d = longint'($signed(pew[k])) - p0;
      neg = d < 0;
      m = neg ? longint'(-d) : d;
      pos[k] = sat_word(p0, (m * h) >> 30, neg);
      vel[k] = sat_word(0, (m * g) / (tt << 30), neg);
      acc[k] = sat_word(0, (m * a) / ((tt * tt) << 28), neg != aneg);
    end
    r = '{pos[0], pos[1], pos[2], vel[0], vel[1], vel[2], acc[0], acc[1], acc[2]};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h want %h", n_got, what, got, want);
  endtask

  function automatic bit idles(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // driver: a new transfer is offered only once the previous one has gone
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        awaited_prof.push_back(min_jerk_point({start_x, start_y, start_z, end_x, end_y, end_z,
                                               duration, elapsed}));
        n_sent++;
      end
      if (pending_sp.size() > 0 && !idles(phase == 0 ? 10 : phase == 1 ? 74 : 0)) begin
        setpoint_t sp;
        sp = pending_sp.pop_front();
        {start_x, start_y, start_z, end_x, end_y, end_z, duration, elapsed} <= sp;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // phase of idling follows the number of transfers taken in
  always @(posedge clk) phase <= (n_sent < 620) ? 0 : (n_sent < 1240) ? 1 : 2;

  // long hold-off so the pipeline fills and the input stalls
  always @(posedge clk) begin
    if (!rst && !hold_done && n_sent >= 300) begin
      hold_cnt <= 400;
      hold_done <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= (hold_cnt > 0) || idles(phase == 0 ? 74 : phase == 1 ? 10 : 0);
  end

  // monitor: compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_prof.size() == 0) begin
        errors++;
        $display("unexpected result transfer");
      end else begin
        profile_t w;
        w = awaited_prof.pop_front();
        if (pos_x !== w.px) report("pos_x", pos_x, w.px);
        if (pos_y !== w.py) report("pos_y", pos_y, w.py);
        if (pos_z !== w.pz) report("pos_z", pos_z, w.pz);
        if (vel_x !== w.vx) report("vel_x", vel_x, w.vx);
        if (vel_y !== w.vy) report("vel_y", vel_y, w.vy);
        if (vel_z !== w.vz) report("vel_z", vel_z, w.vz);
        if (acc_x !== w.ax) report("acc_x", acc_x, w.ax);
        if (acc_y !== w.ay) report("acc_y", acc_y, w.ay);
        if (acc_z !== w.az) report("acc_z", acc_z, w.az);
      end
      n_got++;
    end
  end

  function automatic logic [31:0] rnd_pos();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    setpoint_t sp;
    logic [31:0] mx, px;
    mx = 32'h8000_0000;
    px = 32'h7FFF_FFFF;
    // directed: full-scale moves, both directions, all the special points in time
    pending_sp.push_back('{mx, mx, px, px, px, mx, 16'd1, 16'd0});
    pending_sp.push_back('{mx, mx, px, px, px, mx, 16'd1, 16'd1});
    pending_sp.push_back('{mx, px, 0, px, mx, 0, 16'd2, 16'd1});
    pending_sp.push_back('{mx, px, 0, px, mx, 0, 16'd3, 16'd1});
    pending_sp.push_back('{mx, px, 0, px, mx, 0, 16'd3, 16'd2});
    pending_sp.push_back('{0, 0, 0, px, mx, 32'h10000, 16'd0, 16'd0});   // zero duration
    pending_sp.push_back('{0, 0, 0, px, mx, 32'h10000, 16'd0, 16'd1});
    pending_sp.push_back('{0, 0, 0, px, mx, 32'h10000, 16'd0, 16'd2});   // past the end
    pending_sp.push_back('{1, 2, 3, 4, 5, 6, 16'hFFFF, 16'hFFFF});       // at the end
    pending_sp.push_back('{1, 2, 3, 4, 5, 6, 16'hFFFF, 16'h7FFF});
    pending_sp.push_back('{mx, mx, mx, px, px, px, 16'hFFFF, 16'h8000});
    pending_sp.push_back('{px, px, px, mx, mx, mx, 16'hFFFF, 16'h0001});
    pending_sp.push_back('{px, px, px, mx, mx, mx, 16'hFFFE, 16'hFFFF}); // past the end
    pending_sp.push_back('{5, 5, 5, 5, 5, 5, 16'd10, 16'd5});            // no move
    pending_sp.push_back('{mx, 0, px, mx, 0, px, 16'h8000, 16'h4000});
    pending_sp.push_back('{32'h0001_0000, 32'hFFFF_0000, 0, 32'h000A_0000, 32'hFFF6_0000, 0,
                           16'd100, 16'd25});
    pending_sp.push_back('{32'h0001_0000, 32'hFFFF_0000, 0, 32'h000A_0000, 32'hFFF6_0000, 0,
                           16'd100, 16'd75});
    for (int i = 0; i < 1850; i++) begin
      sp.sx = rnd_pos(); sp.sy = rnd_pos(); sp.sz = rnd_pos();
      sp.ex = rnd_pos(); sp.ey = rnd_pos(); sp.ez = rnd_pos();
      case ($urandom_range(9))
        0: sp.dur = 16'($urandom_range(3));
        1, 2: sp.dur = 16'($urandom);
        default: sp.dur = 16'($urandom_range(1, 500));
      endcase
      case ($urandom_range(9))
        0: sp.elp = 16'($urandom);
        1: sp.elp = sp.dur;
        2: sp.elp = (sp.dur == 16'hFFFF) ? sp.dur : sp.dur + 16'($urandom_range(1, 3));
        default: sp.elp = (sp.dur == 0) ? 16'd0 : 16'($urandom_range(sp.dur));
      endcase
      pending_sp.push_back(sp);
    end
    repeat (9) @(posedge clk);
    rst <= 0;
    wait (pending_sp.size() == 0 && !in_valid);
    wait (awaited_prof.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d set-points, %0d results; full-scale, zero-duration, at and past the end",
             n_sent, n_got);
    $display("idling on either side, then none, with one long output hold-off");
    if (errors == 0 && awaited_prof.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qtp_pkg.sv
rtl/core/qtp_sdiv.sv
rtl/core/qtp_shape.sv
rtl/core/qtp_axis.sv
rtl/core/quintic_trajectory_point.sv
tb/tb.sv
